// ===== rtl/jds_pkg.sv =====
// Shared types, constants and helpers for the JPEG dimension scanner.
`default_nettype none
package jds_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int COUNT_W     = LENGTH_BITS + 1;
  localparam int POS_W       = LENGTH_BITS + 2;
  localparam int DIFF_W      = POS_W + 1;
  localparam int NEXT_W      = POS_W + 1;

  localparam int HEAD_N      = 11;
  localparam int WIN_N       = 9;
  localparam int MIN_LENGTH  = 24;
  localparam int LOOKAHEAD   = 12;
  localparam int START_POS   = 2;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] CHR_J    = 8'h4A;
  localparam logic [7:0] CHR_F    = 8'h46;
  localparam logic [7:0] CHR_I    = 8'h49;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_NO_DIM  = 2'd2;
  localparam logic [1:0] ST_EARLY   = 2'd3;

  localparam logic [1:0] PH_WALK = 2'd0;
  localparam logic [1:0] PH_STOP = 2'd1;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [LENGTH_BITS-1:0] image_length;
    logic                   last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  status;
  } result_t;

  function automatic logic is_sof(input logic [7:0] m);
    is_sof = (m == 8'hC0) || (m == 8'hC1) || (m == 8'hC2) || (m == 8'hC3) ||
             (m == 8'hC9) || (m == 8'hCA) || (m == 8'hCB);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/jds_in_reg.sv =====
// Input register holding one byte beat in front of the scanner core.
`default_nettype none
module jds_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire jds_pkg::byte_beat_t byte_data,
  input  wire logic               take,
  output logic                    held_valid,
  output jds_pkg::byte_beat_t     held
);
  import jds_pkg::*;

  assign byte_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_ready) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      held <= byte_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jds_core.sv =====
// Scanner state: byte counter, head bytes, segment window and marker walk.
`default_nettype none
module jds_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire jds_pkg::byte_beat_t item,
  output jds_pkg::result_t         result
);
  import jds_pkg::*;

  logic [COUNT_W-1:0]     byte_count;
  logic [7:0]             head_bytes [HEAD_N];
  logic [7:0]             window_bytes [WIN_N];
  logic [POS_W-1:0]       segment_pos;
  logic [1:0]             scan_phase;
  logic [LENGTH_BITS-1:0] sampled_length;

  logic [COUNT_W-1:0]     byte_count_next;
  logic [7:0]             head_next [HEAD_N];
  logic [7:0]             win_w [WIN_N];
  logic [7:0]             window_next [WIN_N];
  logic [7:0]             view [WIN_N];
  logic [POS_W-1:0]       segment_pos_next;
  logic [1:0]             scan_phase_next;
  logic [LENGTH_BITS-1:0] len_eff;

  logic [DIFF_W-1:0]      idx_x;
  logic [DIFF_W-1:0]      pos_x;
  logic [DIFF_W-1:0]      off;
  logic                   in_win;
  logic                   decide;
  logic [15:0]            seg_len;
  logic [NEXT_W-1:0]      next_x;
  logic                   overrun;
  logic                   stop;
  logic [16:0]            hop;
  logic [17:0]            src;
  logic                   jfif;

  always_comb begin
    src     = '0;
    len_eff = (byte_count == '0) ? item.image_length : sampled_length;
    idx_x   = DIFF_W'(byte_count);
    pos_x   = DIFF_W'(segment_pos);
    off     = idx_x - pos_x;
    in_win  = (idx_x >= pos_x) && (off < DIFF_W'(WIN_N));
    decide  = (scan_phase == PH_WALK) && (idx_x == pos_x + DIFF_W'(3));

    for (int k = 0; k < HEAD_N; k++) begin
      head_next[k] = (byte_count == COUNT_W'(k)) ? item.data_byte : head_bytes[k];
    end
    for (int k = 0; k < WIN_N; k++) begin
      win_w[k] = (in_win && off[3:0] == 4'(k)) ? item.data_byte : window_bytes[k];
    end

    // next segment = pos + 2 + big-endian length; must leave room for lookahead
    seg_len = {win_w[2], win_w[3]};
    next_x  = NEXT_W'(segment_pos) + NEXT_W'(seg_len) + NEXT_W'(START_POS);
    overrun = (next_x + NEXT_W'(LOOKAHEAD)) > NEXT_W'(len_eff);
    stop    = (win_w[0] != MARK_FF) || is_sof(win_w[1]) || overrun;
    hop     = 17'(seg_len) + 17'd2;

    window_next      = win_w;
    segment_pos_next = segment_pos;
    scan_phase_next  = scan_phase;
    if (decide) begin
      if (stop) begin
        scan_phase_next = PH_STOP;
      end else begin
        segment_pos_next = next_x[POS_W-1:0];
        for (int k = 0; k < WIN_N; k++) begin
          src = 18'(k) + 18'(hop);
          window_next[k] = (src < 18'(WIN_N)) ? win_w[src[3:0]] : 8'h00;
        end
      end
    end

    byte_count_next = (byte_count == '1) ? byte_count : byte_count + COUNT_W'(1);

    jfif = (head_next[0] == MARK_FF) && (head_next[1] == MARK_SOI) &&
           (head_next[2] == MARK_FF) && (head_next[3] == MARK_APP0) &&
           (head_next[6] == CHR_J) && (head_next[7] == CHR_F) &&
           (head_next[8] == CHR_I) && (head_next[9] == CHR_F);
    for (int k = 0; k < WIN_N; k++) begin
      view[k] = jfif ? window_next[k] : head_next[k + 2];
    end

    result = '0;
    if (len_eff < LENGTH_BITS'(MIN_LENGTH)) begin
      result.status = ST_SHORT;
    end else if (byte_count_next < COUNT_W'(len_eff)) begin
      result.status = ST_EARLY;
    end else if ((head_next[0] == MARK_FF) && (head_next[1] == MARK_SOI) &&
                 (view[0] == MARK_FF)) begin
      result.status = ST_OK;
      result.width  = {view[7], view[8]};
      result.height = {view[5], view[6]};
    end else begin
      result.status = ST_NO_DIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_count     <= '0;
      segment_pos    <= POS_W'(START_POS);
      scan_phase     <= PH_WALK;
      sampled_length <= '0;
      for (int k = 0; k < HEAD_N; k++) head_bytes[k] <= 8'h00;
      for (int k = 0; k < WIN_N; k++) window_bytes[k] <= 8'h00;
    end else if (step) begin
      byte_count     <= byte_count_next;
      segment_pos    <= segment_pos_next;
      scan_phase     <= scan_phase_next;
      sampled_length <= len_eff;
      head_bytes     <= head_next;
      window_bytes   <= window_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jds_out_reg.sv =====
// Result register: holds one report until the downstream side takes it.
`default_nettype none
module jds_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire jds_pkg::result_t load_data,
  output logic                  free,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output jds_pkg::result_t      result_data
);
  import jds_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jpeg_dimension_scanner.sv =====
// Top level of the JPEG dimension scanner.
// Takes a JPEG file one byte per beat and, on the beat flagged last_byte, returns one
// report with width, height and status (0 ok, 1 declared length below 24, 2 no
// dimensions found, 3 stream ended before the declared length). One byte is taken
// per cycle; each byte is held in the input register, and at the edge on which the
// core steps it the core updates the counter, head and segment window; for the last
// byte it also loads the report into the output register, which raises result_valid.
// The rate drops only when a report waits in the output register and another last
// byte arrives. After each last byte all core state returns to its reset values.
`default_nettype none
module jpeg_dimension_scanner (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire jds_pkg::byte_beat_t byte_data,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output jds_pkg::result_t         result_data
);
  import jds_pkg::*;

  logic       held_valid;
  byte_beat_t held;
  logic       out_free;
  logic       step;
  result_t    core_result;

  // a last byte may only advance when its report has somewhere to go
  assign step = held_valid && (!held.last_byte || out_free);

  jds_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .take       (step),
    .held_valid (held_valid),
    .held       (held)
  );

  jds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held),
    .result (core_result)
  );

  jds_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step && held.last_byte),
    .load_data    (core_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule
`default_nettype wire
